/* sv/ppt_pkg.sv */
// ppt_pkg: shared types and constants of the position and pnl tracker
// used by ppt_div and position_pnl_tracker, no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ppt_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 64;

  localparam int unsigned DIVIDEND_W = 64;
  localparam int unsigned DIVISOR_W  = 32;
  localparam int unsigned QUOT_W     = 32;

  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic signed [31:0] shares;
    logic [31:0]        price;
    logic signed [63:0] realized;
    logic signed [63:0] unrealized;
  } entry_t;

endpackage
`default_nettype wire

/* sv/ppt_div.sv */
// ppt_div: restoring unsigned divider, one quotient bit per cycle
// widths from ppt_pkg
`timescale 1ns / 1ps
`default_nettype none
module ppt_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [ppt_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  wire logic [ppt_pkg::DIVISOR_W-1:0]    divisor_i,
  output      logic                             done_o,
  output      logic [ppt_pkg::QUOT_W-1:0]       quotient_o
);

  localparam int unsigned DW = ppt_pkg::DIVIDEND_W;
  localparam int unsigned VW = ppt_pkg::DIVISOR_W;
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] dq_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;

  logic [VW-1:0] shifted;
  logic [VW:0]   trial;

  assign shifted = {rem_q[VW-2:0], dq_q[DW-1]};
  assign trial   = {1'b0, shifted} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(DW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= trial[VW] ? shifted : trial[VW-1:0];
      dq_q  <= {dq_q[DW-2:0], ~trial[VW]};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q[ppt_pkg::QUOT_W-1:0];

endmodule
`default_nettype wire

/* sv/position_pnl_tracker.sv */
// position_pnl_tracker: average-cost position table with realized and unrealized pnl
// depends on ppt_pkg and ppt_div
//
// channel  dir  handshake               payload
// in       in   in_valid_i/in_ready_o   operation, symbol_index, fill_shares, price
// out      out  out_valid_o/out_ready_i status, held_shares, avg_price, gains, notional
//
// one item at a time, from transfer to transfer
// a fill that grows a position also runs the cost products and the divider
// the 64-step divider and the one-slot-per-cycle totals walk over the table memory set the pace
// after reset a clearing pass over all NUM_SLOTS slots runs before the first transfer is taken
// a finished result waits in the output register; the next item is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none
module position_pnl_tracker #(
  parameter int unsigned NUM_SLOTS = ppt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [5:0]         symbol_index_i,
  input  wire logic signed [20:0] fill_shares_i,
  input  wire logic [31:0]        price_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               status_o,
  output      logic signed [31:0] held_shares_o,
  output      logic [31:0]        avg_price_o,
  output      logic signed [63:0] realized_gain_o,
  output      logic signed [63:0] unrealized_gain_o,
  output      logic signed [63:0] total_gain_o,
  output      logic [62:0]        total_notional_o
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int unsigned ACC_W = 64 + $clog2(NUM_SLOTS) + 2;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_REAL  = 4'd4;
  localparam logic [3:0] S_POS   = 4'd5;
  localparam logic [3:0] S_COST1 = 4'd6;
  localparam logic [3:0] S_COST2 = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_MARK  = 4'd9;
  localparam logic [3:0] S_WRITE = 4'd10;
  localparam logic [3:0] S_WALK  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  logic [3:0] state_q, state_d;

  ppt_pkg::entry_t mem [NUM_SLOTS];
  ppt_pkg::entry_t rdata_q;
  ppt_pkg::entry_t wdata;
  logic [IDX_W-1:0] raddr, waddr;
  logic             we;

  logic [1:0]         op_q;
  logic [5:0]         idx_q;
  logic signed [20:0] s_q;
  logic [31:0]        price_q;
  logic               in_range_q;
  logic               status_q;

  logic signed [31:0] sh_q;
  logic [31:0]        ep_q;
  logic signed [63:0] rz_q;
  logic signed [63:0] ur_q;
  logic signed [32:0] nw_q;

  logic [CNT_W-1:0] clr_q;
  logic [CNT_W-1:0] iss_q;
  logic             v1_q, v2_q;
  logic signed [64:0]      sum_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [62:0]             note_q;
  logic [63:0]             cost_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  logic        div_start, div_done;
  logic [31:0] quot;

  // fill arithmetic on the loaded entry
  logic signed [32:0] diff, diff_adj, nw;
  logic [32:0]        abs_sh, abs_s, abs_nw, red;
  logic               ovf, reduce, same_side, grow;
  logic signed [66:0] rsum;
  logic [63:0]        nsum;
  logic               issuing, in_range_i;

  assign diff     = $signed({1'b0, price_q}) - $signed({1'b0, ep_q});
  assign diff_adj = sh_q[31] ? -diff : diff;
  assign nw       = 33'(sh_q) + 33'(s_q);
  assign ovf      = nw[32] != nw[31];
  assign abs_sh   = abs33(33'(sh_q));
  assign abs_s    = abs33(33'(s_q));
  assign abs_nw   = abs33(nw_q);
  assign red      = (abs_s < abs_sh) ? abs_s : abs_sh;
  assign reduce   = ((sh_q > 0) && (s_q < 0)) || ((sh_q < 0) && (s_q > 0));
  assign same_side = ((sh_q >= 0) && (nw_q >= 0)) || ((sh_q <= 0) && (nw_q <= 0));
  assign grow     = abs_nw > abs_sh;
  assign rsum     = 67'(rz_q) + 67'(prod_q);
  assign nsum     = {1'b0, note_q} + {1'b0, prod_q[62:0]};
  assign issuing  = (state_q == S_WALK) && (iss_q < CNT_W'(NUM_SLOTS));
  assign in_range_i = {7'd0, symbol_index_i} < 13'(NUM_SLOTS);

  assign in_ready_o = state_q == S_IDLE;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_EXEC: begin
        if (op_q == ppt_pkg::OP_FILL) begin
          mul_a = diff_adj;
          mul_b = $signed(red);
        end else begin
          mul_a = diff;
          mul_b = 33'(sh_q);
        end
      end
      S_POS: begin
        mul_a = $signed({1'b0, ep_q});
        mul_b = $signed(abs_sh);
      end
      S_COST1: begin
        mul_a = $signed({1'b0, price_q});
        mul_b = $signed(abs_s);
      end
      S_WALK: begin
        mul_a = $signed(abs33(33'(rdata_q.shares)));
        mul_b = $signed({1'b0, rdata_q.price});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // table memory
  always_comb begin
    raddr = '0;
    if (state_q == S_IDLE) begin
      raddr = IDX_W'(symbol_index_i);
    end else if (state_q == S_WALK) begin
      raddr = iss_q[IDX_W-1:0];
    end
    we    = (state_q == S_CLR) || (state_q == S_WRITE);
    waddr = (state_q == S_CLR) ? clr_q[IDX_W-1:0] : IDX_W'(idx_q);
    wdata = '0;
    if (state_q == S_WRITE) begin
      wdata.shares     = sh_q;
      wdata.price      = ep_q;
      wdata.realized   = rz_q;
      wdata.unrealized = ur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  ppt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cost_q + prod_q[63:0]),
    .divisor_i  (abs_nw[31:0]),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign div_start = state_q == S_COST2;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:   if (clr_q == CNT_W'(NUM_SLOTS - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = in_range_i ? S_LOAD : S_WALK;
      S_LOAD:  state_d = S_EXEC;
      S_EXEC: begin
        case (op_q)
          ppt_pkg::OP_FILL: begin
            if (ovf) begin
              state_d = S_WALK;
            end else begin
              state_d = reduce ? S_REAL : S_POS;
            end
          end
          ppt_pkg::OP_MARK: state_d = (sh_q != 0) ? S_MARK : S_WALK;
          ppt_pkg::OP_QUERY: state_d = S_WALK;
          default: state_d = S_WALK;
        endcase
      end
      S_REAL:  state_d = S_POS;
      S_POS: begin
        if ((nw_q != 0) && same_side && (sh_q != 0) && grow) begin
          state_d = S_COST1;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_COST1: state_d = S_COST2;
      S_COST2: state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_WRITE;
      S_MARK:  state_d = S_WRITE;
      S_WRITE: state_d = S_WALK;
      S_WALK:  if (!issuing && !v1_q && !v2_q) state_d = S_DONE;
      S_DONE:  if (!out_valid_o || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      iss_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q != S_WALK) begin
        iss_q <= '0;
      end else if (issuing) begin
        iss_q <= iss_q + 1'b1;
      end
      v1_q <= issuing;
      v2_q <= v1_q;
      if (state_q == S_DONE && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q       <= operation_i;
        idx_q      <= symbol_index_i;
        s_q        <= fill_shares_i;
        price_q    <= price_i;
        in_range_q <= in_range_i;
        status_q   <= 1'b0;
      end
      S_LOAD: begin
        sh_q <= rdata_q.shares;
        ep_q <= rdata_q.price;
        rz_q <= rdata_q.realized;
        ur_q <= rdata_q.unrealized;
      end
      S_EXEC: begin
        nw_q <= nw;
        if (op_q == ppt_pkg::OP_FILL && ovf) begin
          status_q <= 1'b1;
        end
      end
      S_REAL: begin
        if (rsum[66:63] == 4'b0000 || rsum[66:63] == 4'b1111) begin
          rz_q <= rsum[63:0];
        end else begin
          rz_q <= rsum[66] ? S64_MIN : S64_MAX;
        end
      end
      S_POS: begin
        if (nw_q == 0) begin
          sh_q <= '0;
          ep_q <= '0;
          ur_q <= '0;
        end else if (same_side) begin
          if (sh_q == 0) begin
            ep_q <= price_q;
            sh_q <= nw_q[31:0];
          end else if (!grow) begin
            sh_q <= nw_q[31:0];
          end
        end else begin
          sh_q <= nw_q[31:0];
          ep_q <= price_q;
          ur_q <= '0;
        end
      end
      S_COST1: cost_q <= prod_q[63:0];
      S_DIV: begin
        if (div_done) begin
          ep_q <= quot;
          sh_q <= nw_q[31:0];
        end
      end
      S_MARK: ur_q <= prod_q[63:0];
      S_WRITE: begin
        acc_q  <= '0;
        note_q <= '0;
      end
      default: begin
      end
    endcase
    if (state_q == S_IDLE && in_valid_i && !in_range_i) begin
      acc_q  <= '0;
      note_q <= '0;
    end
    if (state_q == S_EXEC && (state_d == S_WALK)) begin
      acc_q  <= '0;
      note_q <= '0;
    end
    if (v1_q) begin
      sum_q <= 65'(rdata_q.realized) + 65'(rdata_q.unrealized);
    end
    if (v2_q) begin
      acc_q  <= acc_q + ACC_W'(sum_q);
      note_q <= nsum[63] ? {63{1'b1}} : nsum[62:0];
    end
  end

  // result register
  logic tg_fits;
  assign tg_fits = (&acc_q[ACC_W-1:63]) || !(|acc_q[ACC_W-1:63]);

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_o || out_ready_i)) begin
      status_o          <= in_range_q & status_q;
      held_shares_o     <= in_range_q ? sh_q : '0;
      avg_price_o       <= in_range_q ? ep_q : '0;
      realized_gain_o   <= in_range_q ? rz_q : '0;
      unrealized_gain_o <= in_range_q ? ur_q : '0;
      total_gain_o      <= tg_fits ? acc_q[63:0] : (acc_q[ACC_W-1] ? S64_MIN : S64_MAX);
      total_notional_o  <= note_q;
    end
  end

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide step");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE |-> in_range_q)
    else $error("table write for a slot outside the table");

  a_reject_is_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && status_q && in_range_q) |-> op_q == ppt_pkg::OP_FILL)
    else $error("reject status on an operation other than fill");

  a_walk_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q || v2_q) |-> state_q == S_WALK)
    else $error("totals pipeline active outside the walk");

endmodule
`default_nettype wire

/* sim/position_pnl_tracker_tb.sv */
// position_pnl_tracker_tb: self-checking bench for the position and pnl table
// carries its own average-cost predictor; depends on ppt_pkg and position_pnl_tracker
`timescale 1ns / 1ps
module position_pnl_tracker_tb;

  localparam int NSLOT = 64;
  localparam longint S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
  localparam longint S64_MIN = 64'sh8000000000000000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] idx;
    logic signed [20:0] qty;
    logic [31:0] px;
  } order_t;

  typedef struct packed {
    logic st;
    logic signed [31:0] sh;
    logic [31:0] px;
    logic signed [63:0] rg;
    logic signed [63:0] ug;
    logic signed [63:0] tg;
    logic [62:0] tn;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] operation_i = '0;
  logic [5:0] symbol_index_i = '0;
  logic signed [20:0] fill_shares_i = '0;
  logic [31:0] price_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o;
  logic signed [31:0] held_shares_o;
  logic [31:0] avg_price_o;
  logic signed [63:0] realized_gain_o, unrealized_gain_o, total_gain_o;
  logic [62:0] total_notional_o;

  position_pnl_tracker u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic signed [31:0] pos_shares [NSLOT];
  logic [31:0] pos_price [NSLOT];
  logic signed [63:0] pos_realized [NSLOT];
  logic signed [63:0] pos_unreal [NSLOT];

  order_t order_q[$];
  report_t report_q[$];
  int send_idle = 31, recv_idle = 83;
  bit hold_send = 1'b0;
  bit failed = 1'b0;
  bit stim_done = 1'b0;
  longint cycles = 0;

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(S64_MAX)) return S64_MAX;
    if (s < 65'(S64_MIN)) return S64_MIN;
    return s[63:0];
  endfunction

  function automatic logic [63:0] absval(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic report_t book_order(order_t o);
    report_t r;
    int i;
    longint old, nw, q, diff;
    logic [63:0] red, cost;
    logic signed [71:0] acc;
    logic [63:0] note, term;
    r = '0;
    i = o.idx;
    q = longint'(o.qty);
    if (o.op == ppt_pkg::OP_FILL) begin
      old = pos_shares[i];
      nw = old + q;
      if (nw > 64'sh7FFFFFFF || nw < -64'sh80000000) begin
        r.st = 1'b1;
      end else begin
        if ((old > 0 && q < 0) || (old < 0 && q > 0)) begin
          red = absval(q) < absval(old) ? absval(q) : absval(old);
          diff = longint'({32'd0, o.px}) - longint'({32'd0, pos_price[i]});
          if (old < 0) diff = -diff;
          pos_realized[i] = sat_sum(pos_realized[i], diff * longint'(red));
        end
        if (nw == 0) begin
          pos_shares[i] = 0;
          pos_price[i] = 0;
          pos_unreal[i] = 0;
        end else if ((old >= 0 && nw >= 0) || (old <= 0 && nw <= 0)) begin
          if (old == 0) pos_price[i] = o.px;
          else if (absval(nw) > absval(old)) begin
            cost = 64'(pos_price[i]) * absval(old) + 64'(o.px) * absval(q);
            pos_price[i] = 32'(cost / absval(nw));
          end
          pos_shares[i] = 32'(nw);
        end else begin
          pos_shares[i] = 32'(nw);
          pos_price[i] = o.px;
          pos_unreal[i] = 0;
        end
      end
    end else if (o.op == ppt_pkg::OP_MARK && pos_shares[i] != 0) begin
      diff = longint'({32'd0, o.px}) - longint'({32'd0, pos_price[i]});
      pos_unreal[i] = diff * longint'(pos_shares[i]);
    end
    r.sh = pos_shares[i];
    r.px = pos_price[i];
    r.rg = pos_realized[i];
    r.ug = pos_unreal[i];
    acc = '0;
    note = '0;
    for (int k = 0; k < NSLOT; k++) begin
      acc += 72'(pos_realized[k]) + 72'(pos_unreal[k]);
      term = absval(longint'(pos_shares[k])) * 64'(pos_price[k]);
      note = (term > 64'(S64_MAX) - note) ? 64'(S64_MAX) : note + term;
    end
    if (acc > 72'(S64_MAX)) r.tg = S64_MAX;
    else if (acc < 72'(S64_MIN)) r.tg = S64_MIN;
    else r.tg = acc[63:0];
    r.tn = note[62:0];
    return r;
  endfunction

  function automatic order_t mk(logic [1:0] op, logic [5:0] idx, logic signed [20:0] qty,
                                logic [31:0] px);
    order_t o;
    o.op = op; o.idx = idx; o.qty = qty; o.px = px;
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        report_q.push_back(book_order(order_q.pop_front()));
      end
      if (!in_valid_i || in_ready_o) begin
        if (order_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          in_valid_i <= 1'b1;
          operation_i <= order_q[0].op;
          symbol_index_i <= order_q[0].idx;
          fill_shares_i <= order_q[0].qty;
          price_i <= order_q[0].px;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    report_t w;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (cycles > 64'd4000000) begin
        $display("timeout at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (report_q.size() == 0) begin
          $display("%0t unexpected transfer", $time);
          failed = 1'b1;
        end else begin
          w = report_q.pop_front();
          if ({status_o, held_shares_o, avg_price_o, realized_gain_o, unrealized_gain_o,
               total_gain_o, total_notional_o} !== w) begin
            failed = 1'b1;
            $display("%0t mismatch exp st=%0d sh=%0d px=%0h rg=%0d ug=%0d tg=%0d tn=%0d",
                     $time, w.st, w.sh, w.px, w.rg, w.ug, w.tg, w.tn);
            $display("%0t          got st=%0d sh=%0d px=%0h rg=%0d ug=%0d tg=%0d tn=%0d",
                     $time, status_o, held_shares_o, avg_price_o, realized_gain_o,
                     unrealized_gain_o, total_gain_o, total_notional_o);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (order_q.size() != 0 || in_valid_i || report_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_random(int n);
    int k;
    logic [5:0] idx;
    logic signed [20:0] qty;
    logic [31:0] px;
    for (k = 0; k < n; k++) begin
      idx = 6'($urandom_range(7));
      if ($urandom_range(9) == 0) idx = 6'($urandom_range(63));
      case ($urandom_range(5))
        0: qty = 21'($urandom);
        1: qty = 21'($urandom_range(1, 2000));
        2: qty = -21'($urandom_range(1, 2000));
        3: qty = $urandom_range(1) ? 21'sh0FFFFF : -21'sh100000;
        default: qty = 21'($signed($urandom_range(400)) - 200);
      endcase
      case ($urandom_range(3))
        0: px = $urandom;
        1: px = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        default: px = 32'h0064_0000 + $urandom_range(32'h00FF_FFFF);
      endcase
      case ($urandom_range(9))
        0, 1: order_q.push_back(mk(ppt_pkg::OP_MARK, idx, qty, px));
        2: order_q.push_back(mk(ppt_pkg::OP_QUERY, idx, qty, px));
        3: order_q.push_back(mk(OP_SPARE, idx, qty, px));
        default: order_q.push_back(mk(ppt_pkg::OP_FILL, idx, qty, px));
      endcase
    end
  endtask

  initial begin
    for (int k = 0; k < NSLOT; k++) begin
      pos_shares[k] = 0; pos_price[k] = 0; pos_realized[k] = 0; pos_unreal[k] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed cases
    order_q.push_back(mk(ppt_pkg::OP_QUERY, 6'd0, 21'sd0, 32'd0));
    order_q.push_back(mk(ppt_pkg::OP_MARK, 6'd1, 21'sd0, 32'h0010_0000));
    order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd1, 21'sd0, 32'h0010_0000));
    order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd1, 21'sd100, 32'h0010_0000));
    order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd1, 21'sd50, 32'h0020_0000));
    order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd1, -21'sd30, 32'h0030_0000));
    order_q.push_back(mk(ppt_pkg::OP_MARK, 6'd1, 21'sd0, 32'h0008_0000));
    order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd1, -21'sd300, 32'h0005_0000));
    order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd1, 21'sd180, 32'h0006_0000));
    order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd63, 21'sh0FFFFF, 32'hFFFF_FFFF));
    order_q.push_back(mk(ppt_pkg::OP_MARK, 6'd63, 21'sd0, 32'h0));
    order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd62, -21'sh100000, 32'hFFFF_FFFF));
    order_q.push_back(mk(ppt_pkg::OP_MARK, 6'd62, 21'sd0, 32'h0));
    order_q.push_back(mk(OP_SPARE, 6'd62, -21'sd1, 32'h1));
    // stack large buys on one slot
    for (int k = 0; k < 8; k++) begin
      order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd2, 21'sh0FFFFF, 32'h1));
    end
    order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd2, 21'sh0FFFFF, 32'h1));
    // large sells against it at the top price
    order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd2, -21'sh100000, 32'hFFFF_FFFF));
    order_q.push_back(mk(ppt_pkg::OP_FILL, 6'd2, -21'sh100000, 32'hFFFF_FFFF));
    add_random(650);
    wait_drained();
    send_idle = 83; recv_idle = 31;
    hold_send = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_send = 1'b0;
    add_random(650);
    wait_drained();
    send_idle = 0; recv_idle = 0;
    add_random(650);
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (!failed) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* sim.f */
sv/ppt_pkg.sv
sv/ppt_div.sv
sv/position_pnl_tracker.sv
sim/position_pnl_tracker_tb.sv
